FILE: src/uer_pkg.sv
// package for the ultrasonic echo ranger: phase type, register map,
// reset values and status codes; no dependencies
`timescale 1ns / 1ps

package uer_pkg;

   // counter width default
   localparam int CounterBitsDefault = 16;

   // register field widths
   localparam int TrigBits    = 8;
   localparam int TimeoutBits = 20;
   localparam int ScaleBits   = 20;
   localparam int DistBits    = 18;
   localparam int ScaleShift  = 16;

   // configuration port
   localparam int AddrBits = 5;
   localparam int DataBits = 32;
   localparam int IndexBits = 3;

   typedef enum logic [IndexBits-1:0] {
      REG_TRIGGER_TICKS = 3'd0,
      REG_TIMEOUT_TICKS = 3'd1,
      REG_SCALE_Q16     = 3'd2,
      REG_MIN_DISTANCE  = 3'd3,
      REG_MAX_DISTANCE  = 3'd4
   } reg_index_type;

   // reset values of the registers
   localparam logic [TrigBits-1:0]    TriggerTicksReset = 8'd10;
   localparam logic [TimeoutBits-1:0] TimeoutTicksReset = 20'd100000;
   localparam logic [ScaleBits-1:0]   ScaleQ16Reset     = 20'd285213;
   localparam logic [DistBits-1:0]    MinDistanceReset  = 18'd512;
   localparam logic [DistBits-1:0]    MaxDistanceReset  = 18'd102400;

   // saturation limits
   localparam logic [TimeoutBits-1:0] ElapsedMax = '1;
   localparam logic [DistBits-1:0]    DistMax    = '1;
   localparam logic [TrigBits-1:0]    TrigCountMax = '1;

   // status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TIMEOUT   = 2'd1,
      STATUS_OUT_RANGE = 2'd2
   } status_type;

   // measurement phase, one-hot
   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_TRIG = 4'b0010,
      PH_RISE = 4'b0100,
      PH_FALL = 4'b1000
   } phase_type;

endpackage

FILE: src/ultrasonic_echo_ranger.sv
// ultrasonic echo ranger: one tick transaction in, one result transaction out
// path: input register, combinational tick update and multiply, then result register
// throughput: one transaction per cycle while rsp_stall does not hold the result stage
// reset: synchronous, active high; phase idle, counters and captures zero,
// registers at their reset values, both stages empty
// depends on uer_pkg
`timescale 1ns / 1ps

module ultrasonic_echo_ranger #(
   parameter int COUNTER_BITS = uer_pkg::CounterBitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   // tick channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic                          req_echo_level,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_trig_level,
   output logic                          rsp_busy_res,
   output logic                          rsp_done_res,
   output logic [1:0]                    rsp_status,
   output logic [uer_pkg::DistBits-1:0]  rsp_distance_q8,
   // configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [uer_pkg::AddrBits-1:0]  csr_paddr,
   input  logic [uer_pkg::DataBits-1:0]  csr_pwdata,
   output logic [uer_pkg::DataBits-1:0]  csr_prdata,
   output logic                          csr_pready
);

   localparam int ProdBits  = COUNTER_BITS + uer_pkg::ScaleBits;
   localparam int ShiftBits = ProdBits - uer_pkg::ScaleShift;
   localparam int CmpBits   = (ShiftBits > uer_pkg::DistBits) ? ShiftBits : uer_pkg::DistBits;

   // configuration registers
   logic [uer_pkg::TrigBits-1:0]    trigger_ticks_ff;
   logic [uer_pkg::TimeoutBits-1:0] timeout_ticks_ff;
   logic [uer_pkg::ScaleBits-1:0]   scale_q16_ff;
   logic [uer_pkg::DistBits-1:0]    min_distance_ff;
   logic [uer_pkg::DistBits-1:0]    max_distance_ff;
   logic                            csr_write;
   logic [uer_pkg::IndexBits-1:0]   csr_index;

   // input stage
   logic in_valid_ff, in_valid_in;
   logic in_cmd_ff, in_echo_ff;
   logic in_load, out_free, advance;

   // measurement state
   uer_pkg::phase_type              phase_ff, phase_in;
   logic [COUNTER_BITS-1:0]         free_counter_ff, free_counter_in;
   logic [COUNTER_BITS-1:0]         rise_capture_ff, rise_capture_in;
   logic [uer_pkg::TrigBits-1:0]    trigger_count_ff, trigger_count_in;
   logic [uer_pkg::TimeoutBits-1:0] elapsed_ff, elapsed_in;
   logic                            last_echo_ff;

   // result stage
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            trig_ff, busy_ff, done_ff;
   logic [1:0]                      status_ff;
   logic [uer_pkg::DistBits-1:0]    dist_ff;

   // per-tick working values
   logic                            start, rise, fall;
   uer_pkg::phase_type              phase_start;
   logic [uer_pkg::TrigBits-1:0]    trig_count_start;
   logic [uer_pkg::TimeoutBits-1:0] elapsed_start;
   logic [COUNTER_BITS-1:0]         echo_width;
   logic [ProdBits-1:0]             product;
   logic [CmpBits-1:0]              dist_wide;
   logic [uer_pkg::DistBits-1:0]    dist_sat;
   logic                            trig_c, done_c;
   logic [1:0]                      status_c;
   logic [uer_pkg::DistBits-1:0]    dist_c;

   // configuration write and read-back
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[uer_pkg::AddrBits-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ticks_ff <= uer_pkg::TriggerTicksReset;
         timeout_ticks_ff <= uer_pkg::TimeoutTicksReset;
         scale_q16_ff     <= uer_pkg::ScaleQ16Reset;
         min_distance_ff  <= uer_pkg::MinDistanceReset;
         max_distance_ff  <= uer_pkg::MaxDistanceReset;
      end else if (csr_write) begin
         unique case (csr_index)
            uer_pkg::REG_TRIGGER_TICKS: trigger_ticks_ff <= csr_pwdata[uer_pkg::TrigBits-1:0];
            uer_pkg::REG_TIMEOUT_TICKS: timeout_ticks_ff <= csr_pwdata[uer_pkg::TimeoutBits-1:0];
            uer_pkg::REG_SCALE_Q16:     scale_q16_ff     <= csr_pwdata[uer_pkg::ScaleBits-1:0];
            uer_pkg::REG_MIN_DISTANCE:  min_distance_ff  <= csr_pwdata[uer_pkg::DistBits-1:0];
            uer_pkg::REG_MAX_DISTANCE:  max_distance_ff  <= csr_pwdata[uer_pkg::DistBits-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         uer_pkg::REG_TRIGGER_TICKS: csr_prdata = uer_pkg::DataBits'(trigger_ticks_ff);
         uer_pkg::REG_TIMEOUT_TICKS: csr_prdata = uer_pkg::DataBits'(timeout_ticks_ff);
         uer_pkg::REG_SCALE_Q16:     csr_prdata = uer_pkg::DataBits'(scale_q16_ff);
         uer_pkg::REG_MIN_DISTANCE:  csr_prdata = uer_pkg::DataBits'(min_distance_ff);
         uer_pkg::REG_MAX_DISTANCE:  csr_prdata = uer_pkg::DataBits'(max_distance_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // handshake between the two stages
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign advance     = in_valid_ff && out_free;
   assign in_load     = !in_valid_ff || out_free;
   assign req_stall   = !in_load;
   assign in_valid_in = in_load ? req_valid : in_valid_ff;
   assign rsp_valid_in = out_free ? in_valid_ff : rsp_valid_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_cmd_ff  <= req_cmd;
         in_echo_ff <= req_echo_level;
      end
   end

   // echo edges against the previous tick
   assign rise = in_echo_ff && !last_echo_ff;
   assign fall = !in_echo_ff && last_echo_ff;

   // start request only from idle
   assign start            = (phase_ff == uer_pkg::PH_IDLE) && in_cmd_ff;
   assign phase_start      = start ? uer_pkg::PH_TRIG : phase_ff;
   assign trig_count_start = start ? '0 : trigger_count_ff;
   assign elapsed_start    = start ? '0 : elapsed_ff;

   // echo width, scaling and saturation
   assign echo_width = free_counter_ff - rise_capture_ff;
   assign product    = ProdBits'(echo_width) * ProdBits'(scale_q16_ff);
   assign dist_wide  = CmpBits'(product[ProdBits-1:uer_pkg::ScaleShift]);
   assign dist_sat   = (dist_wide > CmpBits'(uer_pkg::DistMax)) ? uer_pkg::DistMax
                                                               : dist_wide[uer_pkg::DistBits-1:0];

   // phase sequencing for one tick
   always_comb begin
      phase_in         = phase_start;
      trigger_count_in = trig_count_start;
      elapsed_in       = elapsed_start;
      rise_capture_in  = rise_capture_ff;
      free_counter_in  = free_counter_ff + COUNTER_BITS'(1);
      trig_c           = 1'b0;
      done_c           = 1'b0;
      status_c         = uer_pkg::STATUS_OK;
      dist_c           = '0;

      if (phase_start != uer_pkg::PH_IDLE) begin
         if (elapsed_start < uer_pkg::ElapsedMax) begin
            elapsed_in = elapsed_start + uer_pkg::TimeoutBits'(1);
         end

         unique case (phase_start)
            uer_pkg::PH_TRIG: begin
               trig_c = 1'b1;
               if (trig_count_start < uer_pkg::TrigCountMax) begin
                  trigger_count_in = trig_count_start + uer_pkg::TrigBits'(1);
               end
               if (trigger_count_in >= trigger_ticks_ff) begin
                  phase_in = uer_pkg::PH_RISE;
               end
            end
            uer_pkg::PH_RISE: begin
               if (rise) begin
                  rise_capture_in = free_counter_ff;
                  phase_in        = uer_pkg::PH_FALL;
               end
            end
            uer_pkg::PH_FALL: begin
               if (fall) begin
                  done_c   = 1'b1;
                  phase_in = uer_pkg::PH_IDLE;
                  if (dist_sat < min_distance_ff || dist_sat > max_distance_ff) begin
                     status_c = uer_pkg::STATUS_OUT_RANGE;
                  end else begin
                     dist_c = dist_sat;
                  end
               end
            end
            default: ;
         endcase

         // timeout after edge handling
         if (!done_c && elapsed_in >= timeout_ticks_ff) begin
            done_c   = 1'b1;
            status_c = uer_pkg::STATUS_TIMEOUT;
            dist_c   = '0;
            trig_c   = 1'b0;
            phase_in = uer_pkg::PH_IDLE;
         end
      end
   end

   // measurement state, updated once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= uer_pkg::PH_IDLE;
         free_counter_ff  <= '0;
         rise_capture_ff  <= '0;
         trigger_count_ff <= '0;
         elapsed_ff       <= '0;
         last_echo_ff     <= 1'b0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         free_counter_ff  <= free_counter_in;
         rise_capture_ff  <= rise_capture_in;
         trigger_count_ff <= trigger_count_in;
         elapsed_ff       <= elapsed_in;
         last_echo_ff     <= in_echo_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         trig_ff   <= trig_c;
         busy_ff   <= (phase_in != uer_pkg::PH_IDLE);
         done_ff   <= done_c;
         status_ff <= status_c;
         dist_ff   <= dist_c;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_trig_level  = trig_ff;
   assign rsp_busy_res    = busy_ff;
   assign rsp_done_res    = done_ff;
   assign rsp_status      = status_ff;
   assign rsp_distance_q8 = dist_ff;

endmodule

FILE: test/ultrasonic_echo_ranger_tb.sv
// self-checking testbench for the ultrasonic echo ranger: directed and random tick traffic,
// an in-bench model of the measurement and register writes over the configuration port
// depends on uer_pkg and ultrasonic_echo_ranger
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_tb;

   localparam int CounterBits = uer_pkg::CounterBitsDefault;
   localparam int RandomItems = 360;
   localparam int QuietLimit  = 5000;

   // one result transaction as the model predicts it
   typedef struct {
      logic                         trig;
      logic                         busy;
      logic                         done;
      uer_pkg::status_type          status;
      logic [uer_pkg::DistBits-1:0] distance;
   } echo_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_cmd = 1'b0;
   logic req_echo_level = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_trig_level;
   logic rsp_busy_res;
   logic rsp_done_res;
   logic [1:0] rsp_status;
   logic [uer_pkg::DistBits-1:0] rsp_distance_q8;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [uer_pkg::AddrBits-1:0] csr_paddr = '0;
   logic [uer_pkg::DataBits-1:0] csr_pwdata = '0;
   logic [uer_pkg::DataBits-1:0] csr_prdata;
   logic csr_pready;

   // register copies used by the model
   logic [uer_pkg::TrigBits-1:0]    cfg_trigger_ticks = uer_pkg::TriggerTicksReset;
   logic [uer_pkg::TimeoutBits-1:0] cfg_timeout_ticks = uer_pkg::TimeoutTicksReset;
   logic [uer_pkg::ScaleBits-1:0]   cfg_scale_q16     = uer_pkg::ScaleQ16Reset;
   logic [uer_pkg::DistBits-1:0]    cfg_min_distance  = uer_pkg::MinDistanceReset;
   logic [uer_pkg::DistBits-1:0]    cfg_max_distance  = uer_pkg::MaxDistanceReset;

   // measurement state of the model
   uer_pkg::phase_type              mirror_phase      = uer_pkg::PH_IDLE;
   logic [CounterBits-1:0]          mirror_counter    = '0;
   logic [CounterBits-1:0]          mirror_rise       = '0;
   logic [uer_pkg::TrigBits-1:0]    mirror_trig_count = '0;
   logic [uer_pkg::TimeoutBits-1:0] mirror_elapsed    = '0;
   logic                            mirror_echo       = 1'b0;

   echo_outcome_type outcomes_due[$];
   int unsigned fault_count = 0;
   int unsigned ticks_sent = 0;
   int unsigned gap_pct = 10;
   int unsigned stall_pct = 10;
   int unsigned stall_left = 0;
   int unsigned quiet_cycles = 0;

   always #5ns clock = ~clock;

   ultrasonic_echo_ranger u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_echo_level  (req_echo_level),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_trig_level  (rsp_trig_level),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_status      (rsp_status),
      .rsp_distance_q8 (rsp_distance_q8),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // advance the model by one tick and return the result it gives
   function automatic echo_outcome_type ranger_tick_outcome(input logic cmd, input logic echo);
      echo_outcome_type res;
      logic [CounterBits-1:0] now;
      logic [CounterBits-1:0] width;
      logic [CounterBits+uer_pkg::ScaleBits-1:0] product;
      logic [CounterBits+uer_pkg::ScaleBits-uer_pkg::ScaleShift-1:0] dist_full;
      logic [uer_pkg::DistBits-1:0] dist_value;
      logic rise;
      logic fall;
      res.trig = 1'b0;
      res.busy = 1'b0;
      res.done = 1'b0;
      res.status = uer_pkg::STATUS_OK;
      res.distance = '0;
      now = mirror_counter;
      rise = echo && !mirror_echo;
      fall = !echo && mirror_echo;
      mirror_echo = echo;
      mirror_counter = now + 1'b1;
      if (mirror_phase == uer_pkg::PH_IDLE && cmd) begin
         mirror_phase = uer_pkg::PH_TRIG;
         mirror_trig_count = '0;
         mirror_elapsed = '0;
      end
      if (mirror_phase != uer_pkg::PH_IDLE) begin
         if (mirror_elapsed != uer_pkg::ElapsedMax)
            mirror_elapsed = mirror_elapsed + 1'b1;
         case (mirror_phase)
            uer_pkg::PH_TRIG: begin
               res.trig = 1'b1;
               if (mirror_trig_count != uer_pkg::TrigCountMax)
                  mirror_trig_count = mirror_trig_count + 1'b1;
               // a zero length behaves as one tick
               if (mirror_trig_count >= cfg_trigger_ticks)
                  mirror_phase = uer_pkg::PH_RISE;
            end
            uer_pkg::PH_RISE: begin
               if (rise) begin
                  mirror_rise = now;
                  mirror_phase = uer_pkg::PH_FALL;
               end
            end
            default: begin
               if (fall) begin
                  width = now - mirror_rise;
                  product = width * cfg_scale_q16;
                  dist_full = product[CounterBits+uer_pkg::ScaleBits-1:uer_pkg::ScaleShift];
                  dist_value = (dist_full > uer_pkg::DistMax) ? uer_pkg::DistMax
                                                              : dist_full[uer_pkg::DistBits-1:0];
                  res.done = 1'b1;
                  if (dist_value < cfg_min_distance || dist_value > cfg_max_distance)
                     res.status = uer_pkg::STATUS_OUT_RANGE;
                  else
                     res.distance = dist_value;
                  mirror_phase = uer_pkg::PH_IDLE;
               end
            end
         endcase
         // timeout only when the tick did not already finish
         if (!res.done && mirror_elapsed >= cfg_timeout_ticks) begin
            res.done = 1'b1;
            res.status = uer_pkg::STATUS_TIMEOUT;
            res.distance = '0;
            res.trig = 1'b0;
            mirror_phase = uer_pkg::PH_IDLE;
         end
      end
      res.busy = (mirror_phase != uer_pkg::PH_IDLE);
      return res;
   endfunction

   // mostly short idle stretches, now and then a long one
   function automatic int unsigned idle_length();
      if ($urandom_range(0, 9) != 0)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic rand_start();
      return ($urandom_range(0, 7) == 0);
   endfunction

   function automatic logic [31:0] reg_mask(input uer_pkg::reg_index_type idx);
      case (idx)
         uer_pkg::REG_TRIGGER_TICKS: return 32'(uer_pkg::TrigCountMax);
         uer_pkg::REG_TIMEOUT_TICKS, uer_pkg::REG_SCALE_Q16: return 32'(uer_pkg::ElapsedMax);
         default: return 32'(uer_pkg::DistMax);
      endcase
   endfunction

   task automatic compare_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         fault_count++;
      end
   endtask

   // one tick transaction, with an optional random gap in front
   task automatic send_tick(input logic cmd, input logic echo);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat (idle_length()) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_echo_level <= echo;
      do @(posedge clock); while (req_stall !== 1'b0);
      outcomes_due.push_back(ranger_tick_outcome(cmd, echo));
      ticks_sent++;
   endtask

   // echo high for width ticks, then low
   task automatic send_pulse(input int unsigned width, input logic noisy);
      repeat (width) send_tick(noisy ? rand_start() : 1'b0, 1'b1);
      send_tick(noisy ? rand_start() : 1'b0, 1'b0);
   endtask

   // hold the sender until every outstanding result has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outcomes_due.size() != 0);
   endtask

   task automatic read_reg(input uer_pkg::reg_index_type idx, output logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // write a register, read it back and update the model copy
   task automatic write_reg(input uer_pkg::reg_index_type idx, input logic [31:0] value);
      logic [31:0] readback;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         uer_pkg::REG_TRIGGER_TICKS: cfg_trigger_ticks = value[uer_pkg::TrigBits-1:0];
         uer_pkg::REG_TIMEOUT_TICKS: cfg_timeout_ticks = value[uer_pkg::TimeoutBits-1:0];
         uer_pkg::REG_SCALE_Q16:     cfg_scale_q16 = value[uer_pkg::ScaleBits-1:0];
         uer_pkg::REG_MIN_DISTANCE:  cfg_min_distance = value[uer_pkg::DistBits-1:0];
         default:                    cfg_max_distance = value[uer_pkg::DistBits-1:0];
      endcase
      read_reg(idx, readback);
      compare_field("register readback", value & reg_mask(idx), readback & reg_mask(idx));
   endtask

   // register reset values, then one measurement with them
   task automatic test_reset_defaults();
      logic [31:0] resets [5] = '{32'(uer_pkg::TriggerTicksReset),
                                  32'(uer_pkg::TimeoutTicksReset),
                                  32'(uer_pkg::ScaleQ16Reset),
                                  32'(uer_pkg::MinDistanceReset),
                                  32'(uer_pkg::MaxDistanceReset)};
      logic [31:0] value;
      for (int i = 0; i < 5; i++) begin
         read_reg(uer_pkg::reg_index_type'(i), value);
         compare_field("register reset value", resets[i],
                       value & reg_mask(uer_pkg::reg_index_type'(i)));
      end
      send_tick(1'b1, 1'b0);
      repeat (9) send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_pulse(120, 1'b0);
   endtask

   // edges while idle and during trigger, start while busy, range limits
   task automatic test_edge_handling();
      drain_results();
      write_reg(uer_pkg::REG_TRIGGER_TICKS, 32'd1);
      write_reg(uer_pkg::REG_TIMEOUT_TICKS, 32'd1000);
      write_reg(uer_pkg::REG_SCALE_Q16, 32'd65536);
      write_reg(uer_pkg::REG_MIN_DISTANCE, 32'd3);
      write_reg(uer_pkg::REG_MAX_DISTANCE, 32'd3);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      // rise inside the trigger pulse and a fall right after are both ignored
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      // exactly on both limits, then just above
      send_tick(1'b1, 1'b0);
      send_pulse(3, 1'b0);
      send_tick(1'b1, 1'b0);
      send_pulse(4, 1'b0);
   endtask

   // timeout in each phase, zero registers, fall on the timeout tick
   task automatic test_timeouts();
      drain_results();
      write_reg(uer_pkg::REG_MIN_DISTANCE, 32'd0);
      write_reg(uer_pkg::REG_MAX_DISTANCE, 32'(uer_pkg::DistMax));
      write_reg(uer_pkg::REG_TIMEOUT_TICKS, 32'd0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      drain_results();
      write_reg(uer_pkg::REG_TIMEOUT_TICKS, 32'd3);
      write_reg(uer_pkg::REG_TRIGGER_TICKS, 32'd5);
      repeat (3) send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      drain_results();
      write_reg(uer_pkg::REG_TRIGGER_TICKS, 32'd0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
   endtask

   // largest scale on a short echo, then a zero scale
   task automatic test_distance_scale();
      drain_results();
      write_reg(uer_pkg::REG_TRIGGER_TICKS, 32'd1);
      write_reg(uer_pkg::REG_TIMEOUT_TICKS, 32'(uer_pkg::ElapsedMax));
      write_reg(uer_pkg::REG_SCALE_Q16, 32'(uer_pkg::ElapsedMax));
      write_reg(uer_pkg::REG_MIN_DISTANCE, 32'd0);
      write_reg(uer_pkg::REG_MAX_DISTANCE, 32'(uer_pkg::DistMax));
      send_tick(1'b1, 1'b0);
      send_pulse(30, 1'b0);
      drain_results();
      write_reg(uer_pkg::REG_SCALE_Q16, 32'd0);
      write_reg(uer_pkg::REG_MAX_DISTANCE, 32'd0);
      send_tick(1'b1, 1'b0);
      send_pulse(7, 1'b0);
   endtask

   // one random measurement attempt, a dead echo or plain noise
   task automatic run_sequence();
      int unsigned kind;
      int unsigned trig_len;
      kind = $urandom_range(0, 11);
      if (kind == 0)
         drain_results();
      if (kind < 8) begin
         trig_len = (cfg_trigger_ticks == 0) ? 1 : cfg_trigger_ticks;
         send_tick(1'b1, 1'($urandom_range(0, 1)));
         repeat (trig_len - 1) send_tick(rand_start(), 1'($urandom_range(0, 1)));
         repeat ($urandom_range(1, 3)) send_tick(rand_start(), 1'b0);
         send_pulse($urandom_range(1, 24), 1'b1);
         repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'b0);
      end else if (kind < 10) begin
         send_tick(1'b1, 1'b0);
         repeat ($urandom_range(1, 60)) send_tick(rand_start(), 1'b0);
      end else begin
         repeat ($urandom_range(1, 8))
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   // random traffic under several register settings and idling mixes
   task automatic test_random_traffic();
      int unsigned first;
      logic [31:0] trig, tmo, scale, lo, hi;
      for (int ph = 0; ph < 6; ph++) begin
         trig = $urandom_range(1, 4);
         tmo = $urandom_range(40, 80);
         scale = $urandom_range(0, 32'(uer_pkg::ElapsedMax));
         lo = $urandom_range(0, 150);
         hi = lo + $urandom_range(0, 300);
         case (ph)
            0: begin
               gap_pct = 0;
               stall_pct = 0;
            end
            1: begin
               trig = 0;
               tmo = 32'(uer_pkg::ElapsedMax);
               scale = 32'(uer_pkg::ElapsedMax);
               lo = 0;
               hi = 32'(uer_pkg::DistMax);
               gap_pct = 30;
               stall_pct = 10;
            end
            2: begin
               trig = 32'(uer_pkg::TrigCountMax);
               tmo = 300;
               scale = 0;
               lo = 0;
               hi = 0;
               gap_pct = 10;
               stall_pct = 30;
            end
            3: begin
               trig = $urandom_range(1, 8);
               tmo = $urandom_range(1, 30);
               lo = $urandom_range(0, 32'(uer_pkg::DistMax));
               hi = $urandom_range(0, 32'(uer_pkg::DistMax));
               gap_pct = 30;
               stall_pct = 30;
            end
            4: begin
               gap_pct = 10;
               stall_pct = 10;
            end
            default: begin
               gap_pct = 0;
               stall_pct = 30;
            end
         endcase
         drain_results();
         write_reg(uer_pkg::REG_TRIGGER_TICKS, trig);
         write_reg(uer_pkg::REG_TIMEOUT_TICKS, tmo);
         write_reg(uer_pkg::REG_SCALE_Q16, scale);
         write_reg(uer_pkg::REG_MIN_DISTANCE, lo);
         write_reg(uer_pkg::REG_MAX_DISTANCE, hi);
         first = ticks_sent;
         while (ticks_sent - first < RandomItems / 6) run_sequence();
      end
   endtask

   // receiver stall bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_stall <= 1'b1;
         stall_left <= idle_length() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare every result transaction with the oldest prediction
   always @(posedge clock) begin : result_check
      echo_outcome_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcomes_due.size() == 0) begin
            $display("%0t ns: result transaction with nothing outstanding", $time);
            fault_count++;
         end else begin
            due = outcomes_due.pop_front();
            compare_field("trig_level", 32'(due.trig), 32'(rsp_trig_level));
            compare_field("busy_res", 32'(due.busy), 32'(rsp_busy_res));
            compare_field("done_res", 32'(due.done), 32'(rsp_done_res));
            compare_field("status", 32'(due.status), 32'(rsp_status));
            compare_field("distance_q8", 32'(due.distance), 32'(rsp_distance_q8));
         end
      end
   end

   // watchdog on cycles without any transaction
   initial begin
      while (quiet_cycles < QuietLimit) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("ultrasonic_echo_ranger regression: fail");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_edge_handling();
      test_timeouts();
      test_distance_scale();
      test_random_traffic();
      drain_results();
      repeat (6) @(posedge clock);
      if (fault_count == 0) begin
         $display("ultrasonic_echo_ranger regression: pass");
      end else begin
         $display("ultrasonic_echo_ranger regression: fail");
      end
      $finish;
   end

endmodule
